>>> sv/dirty_rectangle_tracker_top_macros.svh
// Assertion shorthands shared by the checker files of this block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef DIRTY_RECTANGLE_TRACKER_TOP_MACROS_SVH
`define DIRTY_RECTANGLE_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/drt_pkg.sv
package drt_pkg;

	// Command codes carried in the input tuser field.
	typedef enum logic [1:0] {
		CMD_MARK    = 2'd0,
		CMD_INVAL   = 2'd1,
		CMD_REFRESH = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_SCREEN_WIDTH  = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	// Bits of one screen coordinate; the largest screen is 2^COORD_BITS wide.
	localparam int unsigned COORD_BITS = 10;

	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned RECT_W     = 13;
	localparam int unsigned WIN_POS_W  = 10;
	localparam int unsigned WIN_DIM_W  = 11;

	localparam int unsigned S_DATA_W = 56;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_DATA_W = 48;
	localparam int unsigned M_USER_W = 1;
	localparam int unsigned M_PAD_W  = M_DATA_W - 2 * WIN_POS_W - 2 * WIN_DIM_W;

	localparam int unsigned RST_SCREEN_WIDTH  = 240;
	localparam int unsigned RST_SCREEN_HEIGHT = 320;

	// Width of the sizing arithmetic; holds 2^12 with room to spare.
	localparam int unsigned LIM_W = 14;

	// One update window as it leaves the block.
	typedef struct packed {
		logic                 full_refresh;
		logic [WIN_POS_W-1:0] win_x;
		logic [WIN_POS_W-1:0] win_y;
		logic [WIN_DIM_W-1:0] win_width;
		logic [WIN_DIM_W-1:0] win_height;
	} win_t;

	// Screen dimension as used: zero reads as one, and values above the
	// coordinate range read as the largest screen.
	function automatic logic [LIM_W-1:0] clamp_dim(input logic [LIM_W-1:0] v,
			input logic [LIM_W-1:0] lim);
		logic [LIM_W-1:0] r;
		if (v == '0) begin
			r = LIM_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> sv/drt_cfg.sv
module drt_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  drt_pkg::cfg_reg_t                     cfg_index,
	input  logic [drt_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [drt_pkg::COORD_BITS:0]          screen_w,
	output logic [drt_pkg::COORD_BITS:0]          screen_h,
	output logic [2*(drt_pkg::COORD_BITS+1)-1:0]  half_area
);
	import drt_pkg::*;

	localparam int unsigned DIM_W  = COORD_BITS + 1;
	localparam int unsigned AREA_W = 2 * DIM_W;
	localparam logic [LIM_W-1:0] LIM = LIM_W'(1 << COORD_BITS);
	localparam logic [DIM_W-1:0] RST_W =
		DIM_W'(clamp_dim(LIM_W'(RST_SCREEN_WIDTH), LIM));
	localparam logic [DIM_W-1:0] RST_H =
		DIM_W'(clamp_dim(LIM_W'(RST_SCREEN_HEIGHT), LIM));
	localparam int unsigned RST_HALF = (int'(RST_W) * int'(RST_H)) / 2;

	logic [DIM_W-1:0]  sw_q;
	logic [DIM_W-1:0]  sh_q;
	logic [AREA_W-1:0] half_area_q;
	logic [DIM_W-1:0]  eff_data;
	logic [DIM_W-1:0]  nx_w;
	logic [DIM_W-1:0]  nx_h;
	logic [AREA_W-1:0] area;

	assign eff_data = DIM_W'(clamp_dim(LIM_W'(cfg_data), LIM));

	always_comb begin
		nx_w = sw_q;
		nx_h = sh_q;
		if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  nx_w = eff_data;
				CFG_SCREEN_HEIGHT: nx_h = eff_data;
				default: ;
			endcase
		end
	end

	assign area = AREA_W'(nx_w) * AREA_W'(nx_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q        <= RST_W;
			sh_q        <= RST_H;
			half_area_q <= AREA_W'(RST_HALF);
		end else begin
			sw_q <= nx_w;
			sh_q <= nx_h;
			// Half the screen area is registered together with the size it
			// belongs to.
			half_area_q <= {1'b0, area[AREA_W-1:1]};
		end
	end

	assign screen_w  = sw_q;
	assign screen_h  = sh_q;
	assign half_area = half_area_q;

endmodule

>>> sv/drt_mark.sv
module drt_mark (
	input  logic signed [drt_pkg::RECT_W-1:0] rect_x,
	input  logic signed [drt_pkg::RECT_W-1:0] rect_y,
	input  logic signed [drt_pkg::RECT_W-1:0] rect_w,
	input  logic signed [drt_pkg::RECT_W-1:0] rect_h,
	input  logic [drt_pkg::COORD_BITS:0]      screen_w,
	input  logic [drt_pkg::COORD_BITS:0]      screen_h,
	input  logic                              box_valid,
	input  logic [drt_pkg::COORD_BITS-1:0]    box_left,
	input  logic [drt_pkg::COORD_BITS-1:0]    box_top,
	input  logic [drt_pkg::COORD_BITS-1:0]    box_right,
	input  logic [drt_pkg::COORD_BITS-1:0]    box_bottom,
	output logic                              hit,
	output logic [drt_pkg::COORD_BITS-1:0]    nx_left,
	output logic [drt_pkg::COORD_BITS-1:0]    nx_top,
	output logic [drt_pkg::COORD_BITS-1:0]    nx_right,
	output logic [drt_pkg::COORD_BITS-1:0]    nx_bottom
);
	import drt_pkg::*;

	localparam int unsigned CW = RECT_W + 2;

	logic signed [CW-1:0] x, y, w, h, swe, she;
	logic signed [CW-1:0] cx, cy, cw0, ch0, cw, ch;
	logic [COORD_BITS-1:0] l, t, r, b;

	always_comb begin
		x   = CW'(rect_x);
		y   = CW'(rect_y);
		w   = CW'(rect_w);
		h   = CW'(rect_h);
		swe = signed'(CW'(screen_w));
		she = signed'(CW'(screen_h));

		// Clip the left and top edges at zero, shrinking the extent.
		cx  = (x < 0) ? '0 : x;
		cw0 = (x < 0) ? w + x : w;
		cy  = (y < 0) ? '0 : y;
		ch0 = (y < 0) ? h + y : h;

		// Clip the right and bottom edges at the screen border.
		cw = (cx + cw0 > swe) ? swe - cx : cw0;
		ch = (cy + ch0 > she) ? she - cy : ch0;

		hit = (w > 0) && (h > 0) && (cw > 0) && (ch > 0);

		l = COORD_BITS'(cx);
		t = COORD_BITS'(cy);
		r = COORD_BITS'(cx + cw - CW'(1));
		b = COORD_BITS'(cy + ch - CW'(1));

		if (!box_valid) begin
			nx_left   = l;
			nx_top    = t;
			nx_right  = r;
			nx_bottom = b;
		end else begin
			nx_left   = (l < box_left)   ? l : box_left;
			nx_top    = (t < box_top)    ? t : box_top;
			nx_right  = (r > box_right)  ? r : box_right;
			nx_bottom = (b > box_bottom) ? b : box_bottom;
		end
	end

endmodule

>>> sv/drt_window.sv
module drt_window (
	input  logic                                 box_valid,
	input  logic                                 full_pending,
	input  logic [drt_pkg::COORD_BITS-1:0]       box_left,
	input  logic [drt_pkg::COORD_BITS-1:0]       box_top,
	input  logic [drt_pkg::COORD_BITS-1:0]       box_right,
	input  logic [drt_pkg::COORD_BITS-1:0]       box_bottom,
	input  logic [drt_pkg::COORD_BITS:0]         screen_w,
	input  logic [drt_pkg::COORD_BITS:0]         screen_h,
	input  logic [2*(drt_pkg::COORD_BITS+1)-1:0] half_area,
	output drt_pkg::win_t                        win
);
	import drt_pkg::*;

	localparam int unsigned DIM_W  = COORD_BITS + 1;
	localparam int unsigned AREA_W = 2 * DIM_W;

	logic [DIM_W-1:0]  dw, dh;
	logic [AREA_W-1:0] area;
	logic              outside, full;

	always_comb begin
		// A box that no longer fits a shrunken screen, or is malformed,
		// falls back to a full window.
		outside = (DIM_W'(box_right) >= screen_w) || (DIM_W'(box_bottom) >= screen_h) ||
			(box_right < box_left) || (box_bottom < box_top);
		dw   = DIM_W'(box_right) - DIM_W'(box_left) + DIM_W'(1);
		dh   = DIM_W'(box_bottom) - DIM_W'(box_top) + DIM_W'(1);
		area = AREA_W'(dw) * AREA_W'(dh);
		full = full_pending || !box_valid || outside || (area > half_area);

		if (full) begin
			win.full_refresh = 1'b1;
			win.win_x        = '0;
			win.win_y        = '0;
			win.win_width    = WIN_DIM_W'(screen_w);
			win.win_height   = WIN_DIM_W'(screen_h);
		end else begin
			win.full_refresh = 1'b0;
			win.win_x        = WIN_POS_W'(box_left);
			win.win_y        = WIN_POS_W'(box_top);
			win.win_width    = WIN_DIM_W'(dw);
			win.win_height   = WIN_DIM_W'(dh);
		end
	end

endmodule

>>> sv/dirty_rectangle_tracker_top.sv
// Dirty-rectangle tracker: keeps one bounding box of the screen area that has
// changed since the last refresh and hands out one update window per refresh
// command. The command travels in s_tuser (0 mark, 1 invalidate, 2 refresh;
// 3 is ignored). A mark clips its signed rectangle to the screen and grows the
// box to cover it; an empty rectangle leaves everything unchanged. An
// invalidate forces the next window to be the whole screen. A refresh emits
// exactly one beat on the master side and clears both the box and the pending
// full-screen flag; the window is the whole screen when invalidation is
// pending, when no box is held, when the box no longer fits the screen, or
// when the box covers more than half the screen area. Marks and invalidates
// produce no beat. The block takes one beat every clock cycle unless a refresh
// is held up: each beat sits in an input register while a single stage of
// clip, min/max merge and one area compare works against the box registers,
// and a refresh result lands in the output register, from which its window
// is offered on the master side. A window still waiting in the output
// register holds up only a refresh that reaches the input register; marks
// and invalidates ahead of it keep flowing, and beats behind that refresh
// wait with it. Screen width and height (registers 0 and 1, reset 240 and
// 320) clamp to 1..1024; write them only while the block is idle. A beat
// taken at the same edge as a write already works with the new size.
module dirty_rectangle_tracker_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// From bit 0 up: rect_x, rect_y, rect_w, rect_h (13 bits each, signed),
	// then four zero bits.
	input  logic [drt_pkg::S_DATA_W-1:0]     s_tdata,
	// cmd (2 bits).
	input  logic [drt_pkg::S_USER_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// From bit 0 up: win_x (10), win_y (10), win_width (11), win_height (11),
	// then six zero bits.
	output logic [drt_pkg::M_DATA_W-1:0]     m_tdata,
	// full_refresh (1 bit).
	output logic [drt_pkg::M_USER_W-1:0]     m_tuser,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [drt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import drt_pkg::*;

	localparam int unsigned DIM_W  = COORD_BITS + 1;
	localparam int unsigned AREA_W = 2 * DIM_W;

	// Input register stage.
	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic signed [RECT_W-1:0] rect_x_s1, rect_y_s1, rect_w_s1, rect_h_s1;

	// Tracker state.
	logic                  box_valid_q;
	logic                  full_pending_q;
	logic [COORD_BITS-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;

	// Output register.
	logic out_valid_q;
	win_t win_q;

	logic [DIM_W-1:0]      screen_w, screen_h;
	logic [AREA_W-1:0]     half_area;
	logic                  hit;
	logic [COORD_BITS-1:0] nx_left, nx_top, nx_right, nx_bottom;
	win_t                  win;
	logic                  advance;
	logic                  take;

	drt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_reg_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.screen_w  (screen_w),
		.screen_h  (screen_h),
		.half_area (half_area)
	);

	drt_mark u_mark (
		.rect_x     (rect_x_s1),
		.rect_y     (rect_y_s1),
		.rect_w     (rect_w_s1),
		.rect_h     (rect_h_s1),
		.screen_w   (screen_w),
		.screen_h   (screen_h),
		.box_valid  (box_valid_q),
		.box_left   (box_left_q),
		.box_top    (box_top_q),
		.box_right  (box_right_q),
		.box_bottom (box_bottom_q),
		.hit        (hit),
		.nx_left    (nx_left),
		.nx_top     (nx_top),
		.nx_right   (nx_right),
		.nx_bottom  (nx_bottom)
	);

	drt_window u_window (
		.box_valid    (box_valid_q),
		.full_pending (full_pending_q),
		.box_left     (box_left_q),
		.box_top      (box_top_q),
		.box_right    (box_right_q),
		.box_bottom   (box_bottom_q),
		.screen_w     (screen_w),
		.screen_h     (screen_h),
		.half_area    (half_area),
		.win          (win)
	);

	// The staged beat retires unless it is a refresh whose window has
	// nowhere to go because the output register is still full.
	assign advance  = valid_s1 &&
		((cmd_s1 != CMD_REFRESH) || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1    <= cmd_t'(s_tuser);
			rect_x_s1 <= s_tdata[RECT_W-1:0];
			rect_y_s1 <= s_tdata[2*RECT_W-1:RECT_W];
			rect_w_s1 <= s_tdata[3*RECT_W-1:2*RECT_W];
			rect_h_s1 <= s_tdata[4*RECT_W-1:3*RECT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q    <= 1'b0;
			full_pending_q <= 1'b1;
			box_left_q     <= '0;
			box_top_q      <= '0;
			box_right_q    <= '0;
			box_bottom_q   <= '0;
		end else if (advance) begin
			case (cmd_s1)
				CMD_MARK: begin
					if (hit) begin
						box_valid_q  <= 1'b1;
						box_left_q   <= nx_left;
						box_top_q    <= nx_top;
						box_right_q  <= nx_right;
						box_bottom_q <= nx_bottom;
					end
				end
				CMD_INVAL: begin
					full_pending_q <= 1'b1;
				end
				CMD_REFRESH: begin
					box_valid_q    <= 1'b0;
					full_pending_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (cmd_s1 == CMD_REFRESH)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (cmd_s1 == CMD_REFRESH)) begin
			win_q <= win;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = win_q.full_refresh;
	assign m_tdata  = {{M_PAD_W{1'b0}}, win_q.win_height, win_q.win_width,
		win_q.win_y, win_q.win_x};

endmodule

>>> sv/drt_checker.sv
`include "dirty_rectangle_tracker_top_macros.svh"

module drt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [drt_pkg::M_DATA_W-1:0]     m_tdata,
	input logic [drt_pkg::M_USER_W-1:0]     m_tuser
);
	import drt_pkg::*;

	// A stalled window beat keeps its contents.
	`DRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "window beat changed while stalled")

	// A full-screen window always starts at the origin.
	`DRT_ASSERT_SAME(a_full_origin, m_tvalid && m_tuser[0], m_tdata[2*WIN_POS_W-1:0] == '0, "full window not at origin")

	// Every window covers at least one pixel in each direction.
	`DRT_ASSERT_SAME(a_win_nonempty, m_tvalid, (m_tdata[2*WIN_POS_W+WIN_DIM_W-1:2*WIN_POS_W] != '0) && (m_tdata[2*WIN_POS_W+2*WIN_DIM_W-1:2*WIN_POS_W+WIN_DIM_W] != '0), "empty window")

	// With the output register empty, nothing holds back the input side.
	`DRT_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind dirty_rectangle_tracker_top drt_checker u_drt_checker (.*);

>>> sim/testbench.sv
module testbench;
	import drt_pkg::*;

	// Wait allowance for a refresh beat to pass the input and output registers.
	localparam int LATENCY     = 2;
	localparam int SCREEN_MAX  = 1024;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 86;
	localparam int HOLD_CYCLES = 300;
	localparam int PLAN_ROWS   = 25;

	// Command code 3 has no meaning for the block and must be dropped.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Windows that can be read straight off the reset screen of 240 by 320.
	localparam win_t FULL_RESET = '{1'b1, 10'd0, 10'd0, 11'd240, 11'd320};
	localparam win_t NO_WINDOW  = '0;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [S_USER_W-1:0]   s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [M_USER_W-1:0]   m_tuser;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dirty_rectangle_tracker_top uut (.*);

	always #4 clk = ~clk;

	// One row of the directed part. Rows with a typed window are checked
	// against that window; the others against the predictor.
	typedef struct {
		logic [1:0]         cmd;
		logic signed [12:0] x;
		logic signed [12:0] y;
		logic signed [12:0] w;
		logic signed [12:0] h;
		bit                 typed;
		win_t               want;
	} plan_row_t;

	plan_row_t plan [0:PLAN_ROWS-1] = '{
		// Nothing marked yet and the power-up full refresh is pending.
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1, FULL_RESET},
		'{CMD_MARK,       10,    20,    30,    40, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1,
			win_t'{1'b0, 10'd10, 10'd20, 11'd30, 11'd40}},
		// Zero width, then the most negative height: both are empty.
		'{CMD_MARK,        5,     5,     0,     7, 1'b0, NO_WINDOW},
		'{CMD_MARK,        5,     5,     7, -4096, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1, FULL_RESET},
		// Negative corner gets clipped to the origin.
		'{CMD_MARK,       -5,    -6,    10,    10, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1,
			win_t'{1'b0, 10'd0, 10'd0, 11'd5, 11'd4}},
		// Extreme fields that end up empty after clipping.
		'{CMD_MARK,    -4096, -4096,  4095,  4095, 1'b0, NO_WINDOW},
		'{CMD_MARK,     4095,  4095,  4095,  4095, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1, FULL_RESET},
		// A rectangle larger than the screen covers all of it.
		'{CMD_MARK,     -100,  -100,  4095,  4095, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1, FULL_RESET},
		// An invalidate survives a later mark.
		'{CMD_INVAL,       0,     0,     0,     0, 1'b0, NO_WINDOW},
		'{CMD_MARK,        1,     2,     3,     4, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1, FULL_RESET},
		// Two marks merge; the unused command in between changes nothing.
		'{CMD_MARK,        1,     1,     1,     1, 1'b0, NO_WINDOW},
		'{CMD_UNUSED,     -1,    -1,    -1,    -1, 1'b0, NO_WINDOW},
		'{CMD_MARK,      100,   200,     1,     1, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1,
			win_t'{1'b0, 10'd1, 10'd1, 11'd100, 11'd200}},
		// Exactly half the screen is still sent as a window.
		'{CMD_MARK,        0,     0,   120,   320, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1,
			win_t'{1'b0, 10'd0, 10'd0, 11'd120, 11'd320}},
		// One column more tips it over to a full refresh.
		'{CMD_MARK,        0,     0,   121,   320, 1'b0, NO_WINDOW},
		'{CMD_REFRESH,     0,     0,     0,     0, 1'b1, FULL_RESET},
		// The bottom-right pixel, clipped down from a 5 by 5 square.
		'{CMD_MARK,      239,   319,     5,     5, 1'b0, NO_WINDOW}
	};

	// Predictor state: a copy of the two screen registers and of the box.
	logic [10:0] screen_w;
	logic [10:0] screen_h;
	bit          box_held;
	bit          inval_pending;
	int          left_col;
	int          top_row;
	int          right_col;
	int          bottom_row;

	// Windows predicted for refresh beats that the block has taken but not
	// yet delivered, oldest first.
	win_t pending_windows[$];

	int failures = 0;

	// Sender and receiver pacing. Each side runs in stretches that are either
	// busy (no gaps) or idle (random gaps between beats).
	int tx_left = 0;
	bit tx_idle;
	bit tx_rush = 1'b0;
	int rx_left = 0;
	bit rx_idle;
	int rx_hold_req = 0;

	function automatic int used_dim(input logic [10:0] r);
		if (r == 0)
			return 1;
		if (r > SCREEN_MAX)
			return SCREEN_MAX;
		return int'(r);
	endfunction

	// Clip one rectangle to the screen and grow the box to cover it.
	task automatic mark_box(input int x, input int y, input int w, input int h);
		int sw;
		int sh;
		int x2;
		int y2;
		sw = used_dim(screen_w);
		sh = used_dim(screen_h);
		if (w <= 0 || h <= 0)
			return;
		if (x < 0) begin
			w += x;
			x = 0;
		end
		if (y < 0) begin
			h += y;
			y = 0;
		end
		if (x + w > sw)
			w = sw - x;
		if (y + h > sh)
			h = sh - y;
		if (w <= 0 || h <= 0)
			return;
		x2 = x + w - 1;
		y2 = y + h - 1;
		if (!box_held) begin
			left_col   = x;
			top_row    = y;
			right_col  = x2;
			bottom_row = y2;
			box_held   = 1'b1;
		end else begin
			if (x < left_col)
				left_col = x;
			if (y < top_row)
				top_row = y;
			if (x2 > right_col)
				right_col = x2;
			if (y2 > bottom_row)
				bottom_row = y2;
		end
	endtask

	// Work out the window for a refresh and clear the box and the flag.
	function automatic win_t refresh_window();
		int   sw;
		int   sh;
		int   dw;
		int   dh;
		bit   full;
		win_t r;
		sw = used_dim(screen_w);
		sh = used_dim(screen_h);
		full = inval_pending || !box_held;
		dw = 0;
		dh = 0;
		if (!full) begin
			// A box left over from a larger screen no longer fits.
			if (right_col >= sw || bottom_row >= sh ||
					right_col < left_col || bottom_row < top_row) begin
				full = 1'b1;
			end else begin
				dw = right_col - left_col + 1;
				dh = bottom_row - top_row + 1;
				if (dw * dh > (sw * sh) / 2)
					full = 1'b1;
			end
		end
		if (full)
			r = '{1'b1, 10'd0, 10'd0, 11'(sw), 11'(sh)};
		else
			r = '{1'b0, 10'(left_col), 10'(top_row), 11'(dw), 11'(dh)};
		box_held = 1'b0;
		inval_pending = 1'b0;
		return r;
	endfunction

	task automatic flag(input string msg);
		if (failures < 10)
			$display("%s", msg);
		failures++;
	endtask

	// Offer one input beat after a gap, wait until the block takes it, and
	// then advance the predictor. A typed window replaces the predicted one.
	task automatic send_beat(input logic [1:0] cmd, input logic signed [12:0] x,
			input logic signed [12:0] y, input logic signed [12:0] w,
			input logic signed [12:0] h, input bit typed = 1'b0,
			input win_t want = '0);
		int   gap;
		win_t predicted;
		if (tx_rush) begin
			gap = 0;
		end else begin
			if (tx_left == 0) begin
				tx_left = $urandom_range(4, 30);
				tx_idle = ($urandom_range(0, 2) != 0);
			end
			tx_left--;
			gap = tx_idle ? $urandom_range(0, 17) : 0;
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, h, w, y, x};
		do
			@(posedge clk);
		while (!s_tready);
		if (cmd == CMD_MARK) begin
			mark_box(x, y, w, h);
		end else if (cmd == CMD_INVAL) begin
			inval_pending = 1'b1;
		end else if (cmd == CMD_REFRESH) begin
			predicted = refresh_window();
			pending_windows.push_back(typed ? want : predicted);
		end
	endtask

	// Drop valid, let the block drain, then write both screen registers.
	// Marks leave nothing to wait for, so the task also waits before the write,
	// and again after it before the next beat.
	task automatic set_screen(input int unsigned wd, input int unsigned ht);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_windows.size() == 0);
		repeat (LATENCY + 2) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= 11'(wd);
		@(negedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= 11'(ht);
		@(negedge clk);
		cfg_we <= 1'b0;
		screen_w = 11'(wd);
		screen_h = 11'(ht);
		repeat (2) @(negedge clk);
	endtask

	// Main stimulus: reset, the directed table, then random phases at several
	// screen sizes including the clamped extremes.
	initial begin : stimulus
		int          sent;
		int          n;
		int          x;
		int          y;
		int          w;
		int          h;
		int          sw;
		int          sh;
		logic [1:0]  c;
		int unsigned phase_w [0:6];
		int unsigned phase_h [0:6];

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_SCREEN_WIDTH;
		cfg_data  = '0;

		screen_w      = 11'(RST_SCREEN_WIDTH);
		screen_h      = 11'(RST_SCREEN_HEIGHT);
		box_held      = 1'b0;
		inval_pending = 1'b1;
		left_col      = 0;
		top_row       = 0;
		right_col     = 0;
		bottom_row    = 0;

		// Phase 0 keeps the reset size. Zero reads as one screen pixel and
		// anything above 1024 reads as 1024, so 0 and 2047 probe the clamps.
		phase_w = '{RST_SCREEN_WIDTH, 1, 1024, 0, 2047, 100,
			$urandom_range(1, 1024)};
		phase_h = '{RST_SCREEN_HEIGHT, 1, 1024, 2047, 0, 600,
			$urandom_range(1, 1024)};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++)
			send_beat(plan[i].cmd, plan[i].x, plan[i].y, plan[i].w, plan[i].h,
				plan[i].typed, plan[i].want);

		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0)
				set_screen(phase_w[ph], phase_h[ph]);
			sw = used_dim(screen_w);
			sh = used_dim(screen_h);
			sent = 0;

			// On the largest screen, the receiver goes quiet for a long
			// stretch while refresh beats keep coming, so that the output
			// register fills and the input side has to stall.
			if (ph == 2) begin
				rx_hold_req = HOLD_CYCLES;
				tx_rush = 1'b1;
				repeat (8) send_beat(CMD_REFRESH, 13'($urandom), 13'($urandom),
					13'($urandom), 13'($urandom));
				tx_rush = 1'b0;
				sent += 8;
			end

			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 15) begin
					// Noise: any command with any fields.
					c = 2'($urandom);
					send_beat(c, 13'($urandom), 13'($urandom), 13'($urandom),
						13'($urandom));
					if (c != CMD_UNUSED)
						sent++;
				end else begin
					// A few marks, sometimes an invalidate, then a refresh.
					n = $urandom_range(0, 4);
					repeat (n) begin
						if ($urandom_range(0, 3) != 0) begin
							x = $urandom_range(0, sw - 1);
							y = $urandom_range(0, sh - 1);
							w = $urandom_range(1, sw / 4 + 1);
							h = $urandom_range(1, sh / 4 + 1);
						end else begin
							// Straddles the screen borders, sometimes empty.
							x = int'($urandom_range(0, sw + 127)) - 64;
							y = int'($urandom_range(0, sh + 127)) - 64;
							w = int'($urandom_range(0, sw / 2 + 8)) - 4;
							h = int'($urandom_range(0, sh / 2 + 8)) - 4;
						end
						send_beat(CMD_MARK, 13'(x), 13'(y), 13'(w), 13'(h));
						sent++;
					end
					if ($urandom_range(0, 9) == 0) begin
						send_beat(CMD_INVAL, 13'($urandom), 13'($urandom),
							13'($urandom), 13'($urandom));
						sent++;
					end
					send_beat(CMD_REFRESH, 13'($urandom), 13'($urandom),
						13'($urandom), 13'($urandom));
					sent++;
				end
			end

			// Leave the box at the far corner so that a smaller next screen
			// finds a box that no longer fits.
			send_beat(CMD_MARK, 13'(sw - 1), 13'(sh - 1), 13'sd1, 13'sd1);
			send_beat(CMD_MARK, 13'($urandom_range(0, sw - 1)), 13'sd0, 13'sd1,
				13'sd1);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_windows.size() == 0);
		repeat (LATENCY + 6) @(posedge clk);
		if (failures == 0 && pending_windows.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Receiver: stalls a drawn number of cycles before each result beat,
	// or for the long hold when the stimulus asks for it.
	initial begin : receiver
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req != 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				if (rx_left == 0) begin
					rx_left = $urandom_range(4, 24);
					rx_idle = ($urandom_range(0, 2) != 0);
				end
				rx_left--;
				n = rx_idle ? $urandom_range(0, 17) : 0;
			end
			@(negedge clk);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	// Every result beat must match the oldest predicted window.
	always @(posedge clk) begin : result_check
		win_t got;
		win_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.full_refresh = m_tuser[0];
			got.win_x        = m_tdata[9:0];
			got.win_y        = m_tdata[19:10];
			got.win_width    = m_tdata[30:20];
			got.win_height   = m_tdata[41:31];
			if (pending_windows.size() == 0) begin
				flag($sformatf("unexpected window: full=%0d x=%0d y=%0d w=%0d h=%0d",
					got.full_refresh, got.win_x, got.win_y, got.win_width,
					got.win_height));
			end else begin
				want = pending_windows.pop_front();
				if (got.full_refresh !== want.full_refresh || got.win_x !== want.win_x ||
						got.win_y !== want.win_y || got.win_width !== want.win_width ||
						got.win_height !== want.win_height)
					flag($sformatf({"window mismatch: expected full=%0d x=%0d y=%0d ",
						"w=%0d h=%0d, got full=%0d x=%0d y=%0d w=%0d h=%0d"},
						want.full_refresh, want.win_x, want.win_y, want.win_width,
						want.win_height, got.full_refresh, got.win_x, got.win_y,
						got.win_width, got.win_height));
			end
		end
	end

	// Watchdog: too many cycles in a row without any beat on either side.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

endmodule
